FILE: hdl/mf7i_pkg.sv
// Shared types and constants for the interleaved 7x7 median filter.
// Holds channel payload structs, register indexes and default sizes.
// No dependencies.
package mf7i_pkg;

	localparam int WINDOW_DEF        = 7;
	localparam int COMP_STRIDE_DEF   = 3;
	localparam int MAX_ROW_BYTES_DEF = 8192;

	localparam int SAMPLE_W    = 8;
	localparam int ROW_W       = 16;
	localparam int COL_W       = 13;
	localparam int ROW_BYTES_W = 14;
	localparam int CFG_DATA_W  = 16;

	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 14'd5760;
	localparam logic [ROW_W-1:0]       ROW_COUNT_RST = 16'd1080;

	typedef enum logic [0:0] {
		REG_ROW_BYTES = 1'b0,
		REG_ROW_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                frame_start;
	} pix_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] median;
		logic [ROW_W-1:0]    out_row;
		logic [COL_W-1:0]    out_col;
		logic                last;
	} res_t;

	// Position tag that travels with each window through the selection chain
	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             last;
	} meta_t;

endpackage

FILE: hdl/mf7i_ram.sv
// Generic single-port RAM with registered, read-first output.
// Used for the line store rows. No dependencies.
module mf7i_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem_q[addr];
			if (we) begin
				mem_q[addr] <= wdata;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/mf7i_cell.sv
// One cell of the radix selection chain: settles one bit of the median.
// Depends on mf7i_pkg.
module mf7i_cell
	import mf7i_pkg::*;
#(
	parameter int TAPS   = 49,
	parameter int BITPOS = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [TAPS-1:0][SAMPLE_W-1:0]    in_vals,
	input  logic [TAPS-1:0]                  in_alive,
	input  logic [$clog2(TAPS)-1:0]          in_rank,
	input  logic [SAMPLE_W-1:0]              in_prefix,
	input  meta_t                            in_meta,
	output logic                             out_valid,
	output logic [TAPS-1:0][SAMPLE_W-1:0]    out_vals,
	output logic [TAPS-1:0]                  out_alive,
	output logic [$clog2(TAPS)-1:0]          out_rank,
	output logic [SAMPLE_W-1:0]              out_prefix,
	output meta_t                            out_meta
);

	localparam int RW = $clog2(TAPS);
	localparam int ZW = $clog2(TAPS + 1);

	logic [TAPS-1:0]         slice;
	logic [ZW-1:0]           zeros;
	logic                    take_one;
	logic [TAPS-1:0]         alive_n;
	logic [RW-1:0]           rank_n;
	logic [SAMPLE_W-1:0]     prefix_n;

	logic                        valid_q;
	logic [TAPS-1:0][SAMPLE_W-1:0] vals_q;
	logic [TAPS-1:0]             alive_q;
	logic [RW-1:0]               rank_q;
	logic [SAMPLE_W-1:0]         prefix_q;
	meta_t                       meta_q;

	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			slice[i] = in_vals[i][BITPOS];
		end
	end

	// count candidates with a zero at this bit
	assign zeros    = ZW'($countones(in_alive & ~slice));
	assign take_one = (ZW'(in_rank) >= zeros);

	always_comb begin
		prefix_n = in_prefix;
		if (take_one) begin
			alive_n          = in_alive & slice;
			rank_n           = RW'(ZW'(in_rank) - zeros);
			prefix_n[BITPOS] = 1'b1;
		end else begin
			alive_n = in_alive & ~slice;
			rank_n  = in_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vals_q   <= in_vals;
			alive_q  <= alive_n;
			rank_q   <= rank_n;
			prefix_q <= prefix_n;
			meta_q   <= in_meta;
		end
	end

	assign out_valid  = valid_q;
	assign out_vals   = vals_q;
	assign out_alive  = alive_q;
	assign out_rank   = rank_q;
	assign out_prefix = prefix_q;
	assign out_meta   = meta_q;

endmodule

FILE: hdl/median_filter_7x7_interleaved_unit.sv
// Top level of the interleaved 7x7 median filter.
// Depends on mf7i_pkg, mf7i_ram (line store) and mf7i_cell (selection chain).
//
// Streaming median filter over raster-order bytes whose rows interleave colour
// components. One byte is taken every clock cycle while the result side takes
// results; a stalled result halts the whole pipeline, and input ready falls in
// the same cycle. For each interior byte the median of the 7x7 window over the
// same component (column stride COMP_STRIDE) is carried from the transfer that
// delivers the bottom-right byte of its window through the line store read
// stage, then the window register, then a chain of eight radix selection cells,
// one per bit, the last of which is the output register. The line store is
// WINDOW-1 single-port RAMs of MAX_ROW_BYTES bytes each; its contents are
// undefined after reset and no clearing pass is run. Border bytes and bytes
// past the last row of the frame give no result. Write the configuration
// registers only while the block is idle.
module median_filter_7x7_interleaved_unit
	import mf7i_pkg::*;
#(
	parameter int WINDOW        = WINDOW_DEF,
	parameter int COMP_STRIDE   = COMP_STRIDE_DEF,
	parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_t                  pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HALF   = WINDOW / 2;
	localparam int XREACH = HALF * COMP_STRIDE;
	localparam int SPAN   = 2 * XREACH + 1;
	localparam int SLOTS  = WINDOW - 1;
	localparam int TAPS   = WINDOW * WINDOW;
	localparam int RW     = $clog2(TAPS);
	localparam int CNTW   = $clog2(MAX_ROW_BYTES + 1);
	localparam int CW     = $clog2(MAX_ROW_BYTES);
	localparam int SW     = $clog2(SLOTS);

	// configuration
	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [ROW_W-1:0]       row_count_q;
	logic [CNTW-1:0]        eff;

	// position of the next byte
	logic [ROW_W-1:0] row_q;
	logic [CNTW-1:0]  col_q;
	logic [SW-1:0]    slot_q;

	// position of the byte being taken
	logic [ROW_W-1:0] rp, rn;
	logic [CNTW-1:0]  cp, cn;
	logic [SW-1:0]    sp, sn;
	logic             act;
	logic             emit;
	meta_t            meta_s0;

	logic adv;
	logic accept;

	// stage 1: line store read in flight
	logic                valid_s1;
	logic                emit_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SW-1:0]       slot_s1;
	meta_t               meta_s1;
	logic [SAMPLE_W-1:0] rd [SLOTS];

	// stage 2: window
	logic                valid_s2;
	meta_t               meta_s2;
	logic [SAMPLE_W-1:0] win_s2 [WINDOW][SPAN];
	logic [SAMPLE_W-1:0] col_new [WINDOW];
	logic [SW:0]         rot;

	// selection chain
	logic                          ch_valid  [SAMPLE_W+1];
	logic [TAPS-1:0][SAMPLE_W-1:0] ch_vals   [SAMPLE_W+1];
	logic [TAPS-1:0]               ch_alive  [SAMPLE_W+1];
	logic [RW-1:0]                 ch_rank   [SAMPLE_W+1];
	logic [SAMPLE_W-1:0]           ch_prefix [SAMPLE_W+1];
	meta_t                         ch_meta   [SAMPLE_W+1];

	// ---------------------------------------------------------------
	// Configuration port: always ready, decode the register index
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_RST;
			row_count_q <= ROW_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_BYTES: row_bytes_q <= cfg_data[ROW_BYTES_W-1:0];
				REG_ROW_COUNT: row_count_q <= cfg_data[ROW_W-1:0];
			endcase
		end
	end

	// Effective row length: saturate to the line store size, zero acts as one
	always_comb begin
		if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
			eff = CNTW'(MAX_ROW_BYTES);
		end else if (row_bytes_q == '0) begin
			eff = CNTW'(1);
		end else begin
			eff = CNTW'(row_bytes_q);
		end
	end

	// ---------------------------------------------------------------
	// Stall control: the last chain cell is the output register, so
	// the pipeline moves whenever that register is empty or drained.
	// ---------------------------------------------------------------
	assign adv       = !res_valid || res_ready;
	assign pix_ready = adv;
	assign accept    = pix_valid && adv;

	// ---------------------------------------------------------------
	// Position tracking for the incoming byte
	// ---------------------------------------------------------------
	always_comb begin
		rp = pix.frame_start ? '0 : row_q;
		cp = pix.frame_start ? '0 : col_q;
		sp = pix.frame_start ? '0 : slot_q;
		// wrap left over from a row length change
		if (32'(cp) >= 32'(eff)) begin
			cp = '0;
			if (rp < row_count_q) begin
				rp = ROW_W'(32'(rp) + 1);
				sp = (32'(sp) == SLOTS - 1) ? '0 : SW'(32'(sp) + 1);
			end
		end
		act = (rp < row_count_q);

		cn = CNTW'(32'(cp) + 1);
		rn = rp;
		sn = sp;
		if (32'(cn) >= 32'(eff)) begin
			cn = '0;
			rn = ROW_W'(32'(rp) + 1);
			sn = (32'(sp) == SLOTS - 1) ? '0 : SW'(32'(sp) + 1);
		end

		emit            = (32'(rp) >= 2 * HALF) && (32'(cp) >= 2 * XREACH);
		meta_s0.out_row = ROW_W'(32'(rp) - HALF);
		meta_s0.out_col = COL_W'(32'(cp) - XREACH);
		meta_s0.last    = (32'(rp) + 1 == 32'(row_count_q)) &&
		                  (32'(cp) + 1 == 32'(eff));
	end

	// Advance the position on every transfer; bytes past the frame only
	// keep any wrap that was applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (act) begin
				row_q  <= rn;
				col_q  <= cn;
				slot_q <= sn;
			end else begin
				row_q  <= rp;
				col_q  <= cp;
				slot_q <= sp;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line store: one RAM per buffered row, read-first so the slot being
	// overwritten still returns the byte from WINDOW-1 rows above.
	// ---------------------------------------------------------------
	for (genvar s = 0; s < SLOTS; s++) begin : g_line
		mf7i_ram #(
			.WIDTH(SAMPLE_W),
			.DEPTH(MAX_ROW_BYTES)
		) u_ram (
			.clk  (clk),
			.en   (accept && act),
			.we   (accept && act && (sp == SW'(s))),
			.addr (CW'(cp)),
			.wdata(pix.sample),
			.rdata(rd[s])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid && act;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1   <= emit;
			sample_s1 <= pix.sample;
			slot_s1   <= sp;
			meta_s1   <= meta_s0;
		end
	end

	// ---------------------------------------------------------------
	// Window: rotate the RAM outputs into row order, shift one byte left
	// ---------------------------------------------------------------
	always_comb begin
		rot = '0;
		for (int k = 0; k < SLOTS; k++) begin
			rot = (SW + 1)'(32'(slot_s1) + k);
			if (32'(rot) >= SLOTS) begin
				rot = (SW + 1)'(32'(rot) - SLOTS);
			end
			col_new[k] = rd[SW'(rot)];
		end
		col_new[WINDOW-1] = sample_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			if (valid_s1) begin
				for (int k = 0; k < WINDOW; k++) begin
					for (int j = 0; j < SPAN - 1; j++) begin
						win_s2[k][j] <= win_s2[k][j+1];
					end
					win_s2[k][SPAN-1] <= col_new[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Selection chain: pick the same-component taps, start with every
	// tap a candidate and the rank of the median.
	// ---------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			for (int j = 0; j < WINDOW; j++) begin
				ch_vals[0][k*WINDOW+j] = win_s2[k][j*COMP_STRIDE];
			end
		end
	end

	assign ch_valid[0]  = valid_s2;
	assign ch_alive[0]  = '1;
	assign ch_rank[0]   = RW'(TAPS / 2);
	assign ch_prefix[0] = '0;
	assign ch_meta[0]   = meta_s2;

	for (genvar b = 0; b < SAMPLE_W; b++) begin : g_cell
		mf7i_cell #(
			.TAPS  (TAPS),
			.BITPOS(SAMPLE_W - 1 - b)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (ch_valid[b]),
			.in_vals   (ch_vals[b]),
			.in_alive  (ch_alive[b]),
			.in_rank   (ch_rank[b]),
			.in_prefix (ch_prefix[b]),
			.in_meta   (ch_meta[b]),
			.out_valid (ch_valid[b+1]),
			.out_vals  (ch_vals[b+1]),
			.out_alive (ch_alive[b+1]),
			.out_rank  (ch_rank[b+1]),
			.out_prefix(ch_prefix[b+1]),
			.out_meta  (ch_meta[b+1])
		);
	end

	// Result: the final cell holds the finished transfer
	assign res_valid   = ch_valid[SAMPLE_W];
	assign res.median  = ch_prefix[SAMPLE_W];
	assign res.out_row = ch_meta[SAMPLE_W].out_row;
	assign res.out_col = ch_meta[SAMPLE_W].out_col;
	assign res.last    = ch_meta[SAMPLE_W].last;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_row_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res.out_row) >= HALF)
		else $error("result row lies in the top border");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> $stable(rd[0]))
		else $error("line store read data changed during a stall");

	a_candidates: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid[SAMPLE_W] |-> ch_alive[SAMPLE_W] != '0)
		else $error("selection chain lost every candidate");

	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid[SAMPLE_W] |-> 32'(ch_rank[SAMPLE_W]) < $countones(ch_alive[SAMPLE_W]))
		else $error("selection rank beyond remaining candidates");

endmodule
